// ----- src/vct_pkg.sv -----
// Shared types and constants for the voxel crop and threshold classifier.
// Depends on nothing; every other file of the block imports it.
package vct_pkg;

  localparam int MAX_DIM = 4096;
  localparam int POS_W   = $clog2(MAX_DIM);
  localparam int DIM_W   = POS_W + 1;
  localparam int INT_W   = 8;
  localparam int SPACE_W = 32;
  localparam int COORD_W = 44;
  localparam int BOX_W   = 3 * DIM_W;
  localparam int DATA_W  = 64;
  localparam int ADDR_W  = 6;

  localparam logic [DIM_W-1:0] DIM_MAX   = DIM_W'(MAX_DIM);
  localparam logic [POS_W-1:0] SLICE_TOP = POS_W'(MAX_DIM - 1);

  localparam logic [DIM_W-1:0]   RST_ROW_LENGTH = DIM_W'(4096);
  localparam logic [DIM_W-1:0]   RST_ROWS       = DIM_W'(4096);
  localparam logic [BOX_W-1:0]   RST_CROP_LOW   = '0;
  localparam logic [BOX_W-1:0]   RST_CROP_HIGH  = BOX_W'(64'd274911465472);
  localparam logic [SPACE_W-1:0] RST_SPACING    = SPACE_W'(65536);
  localparam logic [INT_W-1:0]   RST_LEVEL      = INT_W'(128);

  typedef enum logic [2:0] {
    REG_ROW_LENGTH,
    REG_ROWS_PER_SLICE,
    REG_CROP_LOW,
    REG_CROP_HIGH,
    REG_SPACING_X,
    REG_SPACING_Y,
    REG_SPACING_Z,
    REG_LEVEL
  } reg_idx_t;

  // Settings as the datapath uses them: sizes already clamped, bounds unpacked.
  typedef struct packed {
    logic [DIM_W-1:0]   cols;
    logic [DIM_W-1:0]   rows;
    logic [DIM_W-1:0]   lo_x;
    logic [DIM_W-1:0]   lo_y;
    logic [DIM_W-1:0]   lo_z;
    logic [DIM_W-1:0]   hi_x;
    logic [DIM_W-1:0]   hi_y;
    logic [DIM_W-1:0]   hi_z;
    logic [SPACE_W-1:0] spacing_x;
    logic [SPACE_W-1:0] spacing_y;
    logic [SPACE_W-1:0] spacing_z;
    logic [INT_W-1:0]   level;
  } cfg_t;

  typedef struct packed {
    logic               is_vessel;
    logic [COORD_W-1:0] coord_x;
    logic [COORD_W-1:0] coord_y;
    logic [COORD_W-1:0] coord_z;
  } result_t;

  function automatic logic [DIM_W-1:0] clamp_size(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_MAX) begin
      r = DIM_MAX;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ----- src/vct_if.sv -----
// Stream channel interfaces for voxel words in and classified words out.
// Depends on vct_pkg for field widths.
interface vct_in_if import vct_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [INT_W-1:0] intensity_byte;
  logic             frame_start;

  modport source(output valid, intensity_byte, frame_start, input ready);
  modport sink(input valid, intensity_byte, frame_start, output ready);
endinterface

interface vct_out_if import vct_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               is_vessel;
  logic [COORD_W-1:0] coord_x;
  logic [COORD_W-1:0] coord_y;
  logic [COORD_W-1:0] coord_z;

  modport source(output valid, is_vessel, coord_x, coord_y, coord_z, input ready);
  modport sink(input valid, is_vessel, coord_x, coord_y, coord_z, output ready);
endinterface

// ----- src/vct_regs.sv -----
// APB-style register file: holds the eight settings and presents them as cfg_t.
// Depends on vct_pkg.
module vct_regs import vct_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output cfg_t              cfg
);

  logic [DIM_W-1:0]   row_length;
  logic [DIM_W-1:0]   rows_per_slice;
  logic [BOX_W-1:0]   crop_low;
  logic [BOX_W-1:0]   crop_high;
  logic [SPACE_W-1:0] spacing_x;
  logic [SPACE_W-1:0] spacing_y;
  logic [SPACE_W-1:0] spacing_z;
  logic [INT_W-1:0]   level;

  reg_idx_t idx;
  logic     wr_en;

  assign idx   = reg_idx_t'(paddr[ADDR_W-1:3]);
  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_length     <= RST_ROW_LENGTH;
      rows_per_slice <= RST_ROWS;
      crop_low       <= RST_CROP_LOW;
      crop_high      <= RST_CROP_HIGH;
      spacing_x      <= RST_SPACING;
      spacing_y      <= RST_SPACING;
      spacing_z      <= RST_SPACING;
      level          <= RST_LEVEL;
    end else if (wr_en) begin
      unique case (idx)
        REG_ROW_LENGTH:     row_length     <= pwdata[DIM_W-1:0];
        REG_ROWS_PER_SLICE: rows_per_slice <= pwdata[DIM_W-1:0];
        REG_CROP_LOW:       crop_low       <= pwdata[BOX_W-1:0];
        REG_CROP_HIGH:      crop_high      <= pwdata[BOX_W-1:0];
        REG_SPACING_X:      spacing_x      <= pwdata[SPACE_W-1:0];
        REG_SPACING_Y:      spacing_y      <= pwdata[SPACE_W-1:0];
        REG_SPACING_Z:      spacing_z      <= pwdata[SPACE_W-1:0];
        REG_LEVEL:          level          <= pwdata[INT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_ROW_LENGTH:     prdata = DATA_W'(row_length);
      REG_ROWS_PER_SLICE: prdata = DATA_W'(rows_per_slice);
      REG_CROP_LOW:       prdata = DATA_W'(crop_low);
      REG_CROP_HIGH:      prdata = DATA_W'(crop_high);
      REG_SPACING_X:      prdata = DATA_W'(spacing_x);
      REG_SPACING_Y:      prdata = DATA_W'(spacing_y);
      REG_SPACING_Z:      prdata = DATA_W'(spacing_z);
      REG_LEVEL:          prdata = DATA_W'(level);
      default:            prdata = '0;
    endcase
  end

  always_comb begin
    cfg.cols      = clamp_size(row_length);
    cfg.rows      = clamp_size(rows_per_slice);
    cfg.lo_x      = crop_low[DIM_W-1:0];
    cfg.lo_y      = crop_low[2*DIM_W-1:DIM_W];
    cfg.lo_z      = crop_low[3*DIM_W-1:2*DIM_W];
    cfg.hi_x      = crop_high[DIM_W-1:0];
    cfg.hi_y      = crop_high[2*DIM_W-1:DIM_W];
    cfg.hi_z      = crop_high[3*DIM_W-1:2*DIM_W];
    cfg.spacing_x = spacing_x;
    cfg.spacing_y = spacing_y;
    cfg.spacing_z = spacing_z;
    cfg.level     = level;
  end

endmodule

// ----- src/vct_cell.sv -----
// Per-voxel classification: crop box test, threshold compare, cell-centre coordinates.
// Purely combinational; depends on vct_pkg.
module vct_cell import vct_pkg::*; (
  input  cfg_t             cfg,
  input  logic [POS_W-1:0] pos_x,
  input  logic [POS_W-1:0] pos_y,
  input  logic [POS_W-1:0] pos_z,
  input  logic [INT_W-1:0] intensity,
  output logic             in_box,
  output result_t          res
);

  localparam int ODD_W  = POS_W + 1;
  localparam int PROD_W = ODD_W + SPACE_W;

  // (2*(pos-low)+1)*spacing, halved; only used when pos >= low.
  function automatic logic [COORD_W-1:0] centre(input logic [POS_W-1:0]   pos,
                                                input logic [DIM_W-1:0]   low,
                                                input logic [SPACE_W-1:0] spacing);
    logic [DIM_W-1:0]  diff;
    logic [ODD_W-1:0]  odd;
    logic [PROD_W-1:0] prod;
    diff = {1'b0, pos} - low;
    odd  = {diff[POS_W-1:0], 1'b1};
    prod = PROD_W'(odd) * PROD_W'(spacing);
    return prod[COORD_W:1];
  endfunction

  logic in_x, in_y, in_z;

  assign in_x   = ({1'b0, pos_x} >= cfg.lo_x) && ({1'b0, pos_x} < cfg.hi_x);
  assign in_y   = ({1'b0, pos_y} >= cfg.lo_y) && ({1'b0, pos_y} < cfg.hi_y);
  assign in_z   = ({1'b0, pos_z} >= cfg.lo_z) && ({1'b0, pos_z} < cfg.hi_z);
  assign in_box = in_x && in_y && in_z;

  assign res.is_vessel = intensity >= cfg.level;
  assign res.coord_x   = centre(pos_x, cfg.lo_x, cfg.spacing_x);
  assign res.coord_y   = centre(pos_y, cfg.lo_y, cfg.spacing_y);
  assign res.coord_z   = centre(pos_z, cfg.lo_z, cfg.spacing_z);

endmodule

// ----- src/voxel_crop_threshold_classifier.sv -----
// Voxel crop and threshold classifier: top level with position counters and pipeline.
// Depends on vct_pkg, vct_if, vct_regs and vct_cell.
//
// One voxel word enters per cycle, unless a stalled output holds back the input
// stage, in raster order (x fastest, then y, then z); frame_start puts the word at
// position zero. A voxel inside the crop box [crop_low, crop_high) passes from the
// input register to the output register as a word holding the vessel flag and its
// cell-centre coordinates in Q28.16; a voxel outside the box gives no word.
// Throughput is one voxel per cycle while the output is not stalled, set by the
// input register and the output register, with the three 13x32 coordinate
// multiplies between them. Settings are written over the APB port at byte address
// 8*index and may only change while no voxel is in flight.
module voxel_crop_threshold_classifier import vct_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  vct_in_if.sink            in_ch,
  vct_out_if.source         out_ch
);

  cfg_t cfg;

  vct_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  assign pready = 1'b1;

  // Position of the next voxel
  logic [POS_W-1:0] col_cnt, row_cnt, slc_cnt;
  logic [POS_W-1:0] col_next, row_next, slc_next;
  logic [POS_W-1:0] pos_i, pos_j, pos_k;

  // Input stage
  logic             s1_valid;
  logic [INT_W-1:0] s1_int;
  logic [POS_W-1:0] s1_i, s1_j, s1_k;

  // Output stage
  logic    out_valid;
  result_t out_word;

  logic    in_acc, s1_adv, in_box;
  result_t res;

  assign pos_i = in_ch.frame_start ? '0 : col_cnt;
  assign pos_j = in_ch.frame_start ? '0 : row_cnt;
  assign pos_k = in_ch.frame_start ? '0 : slc_cnt;

  always_comb begin
    col_next = pos_i + POS_W'(1);
    row_next = pos_j;
    slc_next = pos_k;
    if (({1'b0, pos_i} + DIM_W'(1)) >= cfg.cols) begin
      col_next = '0;
      if (({1'b0, pos_j} + DIM_W'(1)) >= cfg.rows) begin
        row_next = '0;
        // saturate at the last slice
        if (pos_k < SLICE_TOP) begin
          slc_next = pos_k + POS_W'(1);
        end
      end else begin
        row_next = pos_j + POS_W'(1);
      end
    end
  end

  vct_cell u_cell (
    .cfg       (cfg),
    .pos_x     (s1_i),
    .pos_y     (s1_j),
    .pos_z     (s1_k),
    .intensity (s1_int),
    .in_box    (in_box),
    .res       (res)
  );

  // Drop words outside the box; otherwise advance when the output slot frees.
  assign s1_adv      = s1_valid && (!in_box || !out_valid || out_ch.ready);
  assign in_ch.ready = !s1_valid || s1_adv;
  assign in_acc      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt   <= '0;
      row_cnt   <= '0;
      slc_cnt   <= '0;
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_acc) begin
        col_cnt <= col_next;
        row_cnt <= row_next;
        slc_cnt <= slc_next;
      end
      if (in_acc) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv && in_box) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_int <= in_ch.intensity_byte;
      s1_i   <= pos_i;
      s1_j   <= pos_j;
      s1_k   <= pos_k;
    end
    if (s1_adv && in_box) begin
      out_word <= res;
    end
  end

  assign out_ch.valid     = out_valid;
  assign out_ch.is_vessel = out_word.is_vessel;
  assign out_ch.coord_x   = out_word.coord_x;
  assign out_ch.coord_y   = out_word.coord_y;
  assign out_ch.coord_z   = out_word.coord_z;

endmodule

// ----- src/vct_checker.sv -----
// Port-level checks for the voxel classifier, bound to the top level.
// Depends on vct_pkg and on the top level's port names.
module vct_checker import vct_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               pready,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic               out_is_vessel,
  input logic [COORD_W-1:0] out_coord_x,
  input logic [COORD_W-1:0] out_coord_y,
  input logic [COORD_W-1:0] out_coord_z
);

  // Hold a stalled output word
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_is_vessel) && $stable(out_coord_x)
      && $stable(out_coord_y) && $stable(out_coord_z))
    else $error("stalled output word changed");

  // A fresh output word must come from a voxel accepted before it rose
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("output word with no matching input word");

  a_pready: assert property (@(posedge clk) disable iff (rst)
    pready)
    else $error("configuration port not ready");

endmodule

bind voxel_crop_threshold_classifier vct_checker u_vct_checker (
  .clk           (clk),
  .rst           (rst),
  .pready        (pready),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_is_vessel (out_ch.is_vessel),
  .out_coord_x   (out_ch.coord_x),
  .out_coord_y   (out_ch.coord_y),
  .out_coord_z   (out_ch.coord_z)
);

// ----- bench/testbench.sv -----
// Self-checking bench for voxel_crop_threshold_classifier: directed table, a short
// slice-stepping run and randomized frames, each word checked against table or predictor.
// Depends on vct_pkg and the vct_in_if / vct_out_if channel interfaces.
module testbench;
  import vct_pkg::*;

  typedef enum logic {CFG_WRITE, VOXEL} step_kind_t;

  typedef struct {
    step_kind_t        kind;
    reg_idx_t          idx;
    logic [DATA_W-1:0] value;
    logic [INT_W-1:0]  intensity;
    logic              start;
    bit                typed;
    bit                hit;
    result_t           word;
  } step_t;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  vct_in_if  in_ch();
  vct_out_if out_ch();

  voxel_crop_threshold_classifier dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_ch   (in_ch),
    .out_ch  (out_ch)
  );

  // register copies as last written
  logic [12:0]        row_len_reg   = RST_ROW_LENGTH;
  logic [12:0]        rows_reg      = RST_ROWS;
  logic [38:0]        crop_lo_reg   = RST_CROP_LOW;
  logic [38:0]        crop_hi_reg   = RST_CROP_HIGH;
  logic [SPACE_W-1:0] spacing_x_reg = RST_SPACING;
  logic [SPACE_W-1:0] spacing_y_reg = RST_SPACING;
  logic [SPACE_W-1:0] spacing_z_reg = RST_SPACING;
  logic [INT_W-1:0]   level_reg     = RST_LEVEL;

  int unsigned col_pos   = 0;
  int unsigned row_pos   = 0;
  int unsigned slice_pos = 0;

  result_t     expected_words[$];
  int unsigned mismatches = 0;
  bit          in_valid_q = 1'b0;
  bit          in_burst   = 1'b0;
  bit          out_burst  = 1'b0;

  step_t plan [40] = '{
    '{VOXEL, REG_ROW_LENGTH, 0, 255, 1, 1, 1, '{1'b1, 44'd32768, 44'd32768, 44'd32768}},
    '{VOXEL, REG_ROW_LENGTH, 0, 0, 0, 1, 1, '{1'b0, 44'd98304, 44'd32768, 44'd32768}},
    '{VOXEL, REG_ROW_LENGTH, 0, 128, 0, 1, 1, '{1'b1, 44'd163840, 44'd32768, 44'd32768}},
    '{VOXEL, REG_ROW_LENGTH, 0, 127, 0, 1, 1, '{1'b0, 44'd229376, 44'd32768, 44'd32768}},
    // shrink the row below the current column
    '{CFG_WRITE, REG_ROW_LENGTH, 64'd0, 0, 0, 0, 0, '0},
    '{VOXEL, REG_ROW_LENGTH, 0, 200, 0, 0, 0, '0},
    '{VOXEL, REG_ROW_LENGTH, 0, 1, 0, 0, 0, '0},
    '{CFG_WRITE, REG_ROWS_PER_SLICE, 64'd2, 0, 0, 0, 0, '0},
    '{VOXEL, REG_ROW_LENGTH, 0, 90, 0, 0, 0, '0},
    '{VOXEL, REG_ROW_LENGTH, 0, 160, 0, 0, 0, '0},
    '{CFG_WRITE, REG_SPACING_X, 64'hFFFF_FFFF, 0, 0, 0, 0, '0},
    '{CFG_WRITE, REG_SPACING_Y, 64'd0, 0, 0, 0, 0, '0},
    '{CFG_WRITE, REG_SPACING_Z, 64'h8000_0000, 0, 0, 0, 0, '0},
    '{CFG_WRITE, REG_LEVEL, 64'd255, 0, 0, 0, 0, '0},
    '{VOXEL, REG_ROW_LENGTH, 0, 255, 1, 1, 1, '{1'b1, 44'h7FFF_FFFF, 44'd0, 44'h4000_0000}},
    '{VOXEL, REG_ROW_LENGTH, 0, 254, 0, 0, 0, '0},
    '{CFG_WRITE, REG_LEVEL, 64'd0, 0, 0, 0, 0, '0},
    '{VOXEL, REG_ROW_LENGTH, 0, 0, 0, 0, 0, '0},
    // box x [0,1), y [1,2), z [1,3)
    '{CFG_WRITE, REG_CROP_LOW, 64'h400_2000, 0, 0, 0, 0, '0},
    '{CFG_WRITE, REG_CROP_HIGH, 64'hC00_4001, 0, 0, 0, 0, '0},
    '{VOXEL, REG_ROW_LENGTH, 0, 77, 1, 1, 0, '0},
    '{VOXEL, REG_ROW_LENGTH, 0, 33, 0, 0, 0, '0},
    '{VOXEL, REG_ROW_LENGTH, 0, 34, 0, 0, 0, '0},
    '{VOXEL, REG_ROW_LENGTH, 0, 200, 0, 0, 0, '0},
    '{VOXEL, REG_ROW_LENGTH, 0, 201, 0, 0, 0, '0},
    '{VOXEL, REG_ROW_LENGTH, 0, 202, 0, 0, 0, '0},
    '{VOXEL, REG_ROW_LENGTH, 0, 203, 0, 0, 0, '0},
    // inverted x bounds: nothing passes
    '{CFG_WRITE, REG_CROP_LOW, 64'd5, 0, 0, 0, 0, '0},
    '{VOXEL, REG_ROW_LENGTH, 0, 255, 1, 1, 0, '0},
    '{VOXEL, REG_ROW_LENGTH, 0, 0, 0, 1, 0, '0},
    '{CFG_WRITE, REG_CROP_LOW, 64'd0, 0, 0, 0, 0, '0},
    '{CFG_WRITE, REG_CROP_HIGH, 64'h7F_FFFF_FFFF, 0, 0, 0, 0, '0},
    '{CFG_WRITE, REG_ROW_LENGTH, 64'd8191, 0, 0, 0, 0, '0},
    '{CFG_WRITE, REG_ROWS_PER_SLICE, 64'd0, 0, 0, 0, 0, '0},
    '{CFG_WRITE, REG_SPACING_X, 64'h1_0000, 0, 0, 0, 0, '0},
    '{CFG_WRITE, REG_SPACING_Y, 64'hFFFF_FFFF, 0, 0, 0, 0, '0},
    '{CFG_WRITE, REG_LEVEL, 64'd128, 0, 0, 0, 0, '0},
    '{VOXEL, REG_ROW_LENGTH, 0, 255, 1, 1, 1, '{1'b1, 44'd32768, 44'h7FFF_FFFF, 44'h4000_0000}},
    '{VOXEL, REG_ROW_LENGTH, 0, 0, 0, 0, 0, '0},
    '{VOXEL, REG_ROW_LENGTH, 0, 129, 0, 0, 0, '0}
  };

  function automatic int unsigned effective_size(input logic [12:0] raw);
    if (raw == 0) return 1;
    if (raw > MAX_DIM) return MAX_DIM;
    return int'(raw);
  endfunction

  function automatic logic [COORD_W-1:0] cell_centre(input int unsigned pos,
                                                     input int unsigned low,
                                                     input logic [SPACE_W-1:0] spacing);
    logic [63:0] odd;
    logic [63:0] prod;
    odd  = 64'(2 * (pos - low) + 1);
    prod = odd * {32'd0, spacing};
    return prod[COORD_W:1];
  endfunction

  // Classify one voxel at the tracked position, then advance the raster position.
  function automatic bit classify_voxel(input logic [INT_W-1:0] intensity, input logic start,
                                        output result_t word);
    int unsigned cols, rows;
    int unsigned lx, ly, lz, hx, hy, hz;
    bit          hit;
    cols = effective_size(row_len_reg);
    rows = effective_size(rows_reg);
    if (start) begin
      col_pos   = 0;
      row_pos   = 0;
      slice_pos = 0;
    end
    lx = crop_lo_reg[12:0];
    ly = crop_lo_reg[25:13];
    lz = crop_lo_reg[38:26];
    hx = crop_hi_reg[12:0];
    hy = crop_hi_reg[25:13];
    hz = crop_hi_reg[38:26];
    hit = col_pos >= lx && col_pos < hx && row_pos >= ly && row_pos < hy &&
          slice_pos >= lz && slice_pos < hz;
    word = '0;
    if (hit) begin
      word.is_vessel = intensity >= level_reg;
      word.coord_x   = cell_centre(col_pos, lx, spacing_x_reg);
      word.coord_y   = cell_centre(row_pos, ly, spacing_y_reg);
      word.coord_z   = cell_centre(slice_pos, lz, spacing_z_reg);
    end
    // a stale counter at or past its size wraps like one at the size
    if (col_pos + 1 >= cols) begin
      col_pos = 0;
      if (row_pos + 1 >= rows) begin
        row_pos = 0;
        if (slice_pos < MAX_DIM - 1) slice_pos = slice_pos + 1;
      end else begin
        row_pos = row_pos + 1;
      end
    end else begin
      col_pos = col_pos + 1;
    end
    return hit;
  endfunction

  function automatic logic [12:0] draw_size();
    case ($urandom_range(0, 11))
      0: return '0;
      1: return 13'd4096;
      2: return '1;
      3: return 13'($urandom);
      default: return 13'($urandom_range(1, 6));
    endcase
  endfunction

  function automatic logic [SPACE_W-1:0] draw_spacing();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return 32'h0001_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic void draw_axis(input int unsigned dim, output logic [12:0] lo,
                                    output logic [12:0] hi);
    int unsigned span;
    span = (dim > 6) ? 6 : dim;
    case ($urandom_range(0, 9))
      0: begin
        lo = 13'($urandom);
        hi = 13'($urandom);
      end
      1: begin
        lo = 13'($urandom_range(0, span));
        hi = lo;
      end
      2: begin
        lo = '0;
        hi = '1;
      end
      default: begin
        lo = 13'($urandom_range(0, span - 1));
        hi = lo + 13'($urandom_range(1, span));
      end
    endcase
  endfunction

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    mismatches++;
    $display("mismatch %s: got %0h expected %0h", what, got, want);
  endtask

  task automatic apb_write(input reg_idx_t idx, input logic [DATA_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_ROW_LENGTH:     row_len_reg   = value[12:0];
      REG_ROWS_PER_SLICE: rows_reg      = value[12:0];
      REG_CROP_LOW:       crop_lo_reg   = value[38:0];
      REG_CROP_HIGH:      crop_hi_reg   = value[38:0];
      REG_SPACING_X:      spacing_x_reg = value[31:0];
      REG_SPACING_Y:      spacing_y_reg = value[31:0];
      REG_SPACING_Z:      spacing_z_reg = value[31:0];
      REG_LEVEL:          level_reg     = value[7:0];
    endcase
  endtask

  task automatic send_voxel(input logic [INT_W-1:0] intensity, input logic start,
                            input bit typed, input bit typed_hit, input result_t typed_word,
                            output bit hit);
    int unsigned gap;
    result_t     word;
    gap = in_burst ? 0 : $urandom_range(0, 17);
    if ($urandom_range(0, 29) == 0) in_burst = !in_burst;
    if (gap != 0) begin
      if (in_valid_q) begin
        in_ch.valid <= 1'b0;
        in_valid_q = 1'b0;
      end
      repeat (gap) @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.intensity_byte <= intensity;
    in_ch.frame_start    <= start;
    in_valid_q = 1'b1;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    hit = classify_voxel(intensity, start, word);
    if (typed) begin
      hit  = typed_hit;
      word = typed_word;
    end
    if (hit) expected_words.push_back(word);
  endtask

  // Hold input, wait for every pending word, then let the pipeline empty.
  task automatic settle();
    if (in_valid_q) begin
      in_ch.valid <= 1'b0;
      in_valid_q = 1'b0;
    end
    while (expected_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // output stall pattern, one draw per word
  initial begin
    int unsigned stall;
    forever begin
      stall = out_burst ? 0 : $urandom_range(0, 17);
      if ($urandom_range(0, 29) == 0) out_burst = !out_burst;
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!(out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (expected_words.size() == 0) begin
        flag_mismatch("word with nothing pending, coord_x", out_ch.coord_x, '0);
      end else begin
        want = expected_words.pop_front();
        if (out_ch.is_vessel !== want.is_vessel)
          flag_mismatch("is_vessel", out_ch.is_vessel, want.is_vessel);
        if (out_ch.coord_x !== want.coord_x) flag_mismatch("coord_x", out_ch.coord_x, want.coord_x);
        if (out_ch.coord_y !== want.coord_y) flag_mismatch("coord_y", out_ch.coord_y, want.coord_y);
        if (out_ch.coord_z !== want.coord_z) flag_mismatch("coord_z", out_ch.coord_z, want.coord_z);
      end
    end
  end

  initial begin
    bit           hit;
    int unsigned  random_voxels;
    int unsigned  burst_len;
    int unsigned  depth;
    int unsigned  frame_len;
    int unsigned  frame_pos;
    logic [12:0]  new_cols, new_rows;
    logic [12:0]  lo_x, hi_x, lo_y, hi_y, lo_z, hi_z;
    logic [7:0]   lvl;

    rst                  <= 1'b1;
    psel                 <= 1'b0;
    penable              <= 1'b0;
    pwrite               <= 1'b0;
    paddr                <= '0;
    pwdata               <= '0;
    in_ch.valid          <= 1'b0;
    in_ch.intensity_byte <= '0;
    in_ch.frame_start    <= 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[n]) begin
      if (plan[n].kind == CFG_WRITE) begin
        if (n == 0 || plan[n-1].kind != CFG_WRITE) settle();
        apb_write(plan[n].idx, plan[n].value);
      end else begin
        send_voxel(plan[n].intensity, plan[n].start, plan[n].typed, plan[n].hit,
                   plan[n].word, hit);
      end
    end

    // one voxel per slice: step the slice counter on every word
    settle();
    apb_write(REG_ROW_LENGTH, 64'd1);
    apb_write(REG_ROWS_PER_SLICE, 64'd1);
    apb_write(REG_CROP_LOW, 64'd0);
    apb_write(REG_CROP_HIGH, 64'({13'h1FFF, 13'd1, 13'd1}));
    apb_write(REG_SPACING_Z, 64'hFFFF_FFFF);
    apb_write(REG_LEVEL, 64'($urandom_range(0, 255)));
    for (int n = 0; n < 24; n++) begin
      send_voxel(8'($urandom), n == 0, 1'b0, 1'b0, '0, hit);
    end

    random_voxels = 0;
    frame_pos     = 0;
    while (random_voxels < 1680) begin
      settle();
      new_cols = draw_size();
      new_rows = draw_size();
      depth    = $urandom_range(1, 4);
      draw_axis(effective_size(new_cols), lo_x, hi_x);
      draw_axis(effective_size(new_rows), lo_y, hi_y);
      draw_axis(depth, lo_z, hi_z);
      case ($urandom_range(0, 9))
        0: lvl = '0;
        1: lvl = '1;
        default: lvl = 8'($urandom);
      endcase
      apb_write(REG_ROW_LENGTH, 64'(new_cols));
      apb_write(REG_ROWS_PER_SLICE, 64'(new_rows));
      apb_write(REG_CROP_LOW, 64'({lo_z, lo_y, lo_x}));
      apb_write(REG_CROP_HIGH, 64'({hi_z, hi_y, hi_x}));
      apb_write(REG_SPACING_X, 64'(draw_spacing()));
      apb_write(REG_SPACING_Y, 64'(draw_spacing()));
      apb_write(REG_SPACING_Z, 64'(draw_spacing()));
      apb_write(REG_LEVEL, 64'(lvl));

      frame_len = effective_size(new_cols) * effective_size(new_rows) * depth;
      // now and then a frame one voxel too long or too short
      case ($urandom_range(0, 9))
        0: frame_len = frame_len + 1;
        1: if (frame_len > 1) frame_len = frame_len - 1;
        default: ;
      endcase
      // usually open a fresh frame, sometimes carry on from the old position
      frame_pos = ($urandom_range(0, 3) == 0) ? 1 : 0;
      burst_len = $urandom_range(30, 200);
      repeat (burst_len) begin
        send_voxel(8'($urandom), frame_pos == 0 || $urandom_range(0, 59) == 0,
                   1'b0, 1'b0, '0, hit);
        random_voxels++;
        frame_pos = (frame_pos + 1 >= frame_len) ? 0 : frame_pos + 1;
        if ($urandom_range(0, 199) == 0) settle();
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/vct_pkg.sv
src/vct_if.sv
src/vct_regs.sv
src/vct_cell.sv
src/voxel_crop_threshold_classifier.sv
src/vct_checker.sv
bench/testbench.sv
